// File: rtl/core/hcd_pkg.sv
// Package for the HTTP chunked decoder core.
// Holds the parse phase type, status codes, control-state struct and byte helpers.
// No dependencies; compile first.
package hcd_pkg;

	localparam int OUT_LEN_W = 48;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;

	typedef enum logic [2:0] {
		PH_SIZE      = 3'd0,
		PH_DATA      = 3'd1,
		PH_DATA_CRLF = 3'd2,
		PH_LAST_CRLF = 3'd3,
		PH_DONE_OK   = 3'd4,
		PH_DONE_BAD  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUNNING    = 2'd0,
		ST_COMPLETE   = 2'd1,
		ST_MALFORMED  = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	typedef struct packed {
		phase_t phase;
		logic   pending_cr;
		logic   line_bad;
		logic   first_ok;
		logic   pair_second;
	} hcd_ctl_t;

	localparam hcd_ctl_t CTL_RESET = '{
		phase: PH_SIZE, pending_cr: 1'b0, line_bad: 1'b0,
		first_ok: 1'b0, pair_second: 1'b0
	};

	// Returns {is_hex, digit value}.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

// File: rtl/core/hcd_if.sv
// Stream interfaces for the HTTP chunked decoder core: raw body bytes in, results out.
// Depends on nothing; compile after hcd_pkg.
interface hcd_body_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_req;
	logic       in_last;

	modport source (output valid, output in_byte, output start_req, output in_last,
		input ready);
	modport sink (input valid, input in_byte, input start_req, input in_last,
		output ready);
endinterface

interface hcd_result_if;
	logic        valid;
	logic        ready;
	logic        has_byte;
	logic [7:0]  out_byte;
	logic [1:0]  status;
	logic [47:0] decoded_length;
	logic [47:0] consumed_length;

	modport source (output valid, output has_byte, output out_byte, output status,
		output decoded_length, output consumed_length, input ready);
	modport sink (input valid, input has_byte, input out_byte, input status,
		input decoded_length, input consumed_length, output ready);
endinterface

// File: rtl/core/http_chunked_decoder_core.sv
// Top level of the HTTP chunked transfer decoder.
// Depends on hcd_pkg, hcd_if (hcd_body_if, hcd_result_if) and hcd_step.
//
// The body channel takes one raw byte of a chunked HTTP body per word, with
// start_req to begin a new body before that byte and in_last to flag the
// final available byte. The result channel gives exactly one word per body
// word: the decoded data byte when there is one, the parse status and the
// saturating decoded and consumed byte counts.
// A byte is captured in an input register and processed by the parse logic,
// which writes the result into the output register when that register is
// empty or its word is being taken.
// Throughput is one word per cycle while the result receiver keeps up, set by
// the parse state update between the input and output registers.
// Reset clears the parse state to the start of a size line with zero counts
// and empties both registers. When the result receiver stalls, the output
// register holds its word and the input register keeps one more byte; body
// ready drops only when both are occupied.
module http_chunked_decoder_core
	import hcd_pkg::*;
#(
	parameter int SIZE_LIMIT_LOG2 = 40,
	parameter int LENGTH_BITS     = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	hcd_body_if.sink     body,
	hcd_result_if.source result
);

	localparam int CH_W = SIZE_LIMIT_LOG2 + 1;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   start_s1;
	logic                   last_s1;

	hcd_ctl_t               ctl_q;
	logic [CH_W-1:0]        chunk_q;
	logic [CH_W-1:0]        left_q;
	logic [LENGTH_BITS-1:0] decoded_q;
	logic [LENGTH_BITS-1:0] consumed_q;

	hcd_ctl_t               nxt_ctl;
	logic [CH_W-1:0]        nxt_chunk;
	logic [CH_W-1:0]        nxt_left;
	logic [LENGTH_BITS-1:0] nxt_decoded;
	logic [LENGTH_BITS-1:0] nxt_consumed;
	logic                   step_has;
	logic [7:0]             step_byte;
	status_t                step_status;

	logic                   valid_s2;
	logic                   has_s2;
	logic [7:0]             byte_s2;
	status_t                status_s2;
	logic [LENGTH_BITS-1:0] decoded_s2;
	logic [LENGTH_BITS-1:0] consumed_s2;

	logic                   advance;

	assign advance = valid_s1 && (!valid_s2 || result.ready);
	assign body.ready = !valid_s1 || advance;

	hcd_step #(
		.SIZE_LIMIT_LOG2 (SIZE_LIMIT_LOG2),
		.LENGTH_BITS     (LENGTH_BITS)
	) u_step (
		.in_byte      (byte_s1),
		.start_req    (start_s1),
		.in_last      (last_s1),
		.cur_ctl      (ctl_q),
		.cur_chunk    (chunk_q),
		.cur_left     (left_q),
		.cur_decoded  (decoded_q),
		.cur_consumed (consumed_q),
		.nxt_ctl      (nxt_ctl),
		.nxt_chunk    (nxt_chunk),
		.nxt_left     (nxt_left),
		.nxt_decoded  (nxt_decoded),
		.nxt_consumed (nxt_consumed),
		.has_byte     (step_has),
		.out_byte     (step_byte),
		.status       (step_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.valid && body.ready) begin
			byte_s1 <= body.in_byte;
			start_s1 <= body.start_req;
			last_s1 <= body.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= CTL_RESET;
			chunk_q <= '0;
			left_q <= '0;
			decoded_q <= '0;
			consumed_q <= '0;
		end else if (advance) begin
			ctl_q <= nxt_ctl;
			chunk_q <= nxt_chunk;
			left_q <= nxt_left;
			decoded_q <= nxt_decoded;
			consumed_q <= nxt_consumed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			has_s2 <= step_has;
			byte_s2 <= step_byte;
			status_s2 <= step_status;
			decoded_s2 <= nxt_decoded;
			consumed_s2 <= nxt_consumed;
		end
	end

	assign result.valid = valid_s2;
	assign result.has_byte = has_s2;
	assign result.out_byte = byte_s2;
	assign result.status = status_s2;

	generate
		if (LENGTH_BITS >= OUT_LEN_W) begin : g_len_trunc
			assign result.decoded_length = decoded_s2[OUT_LEN_W-1:0];
			assign result.consumed_length = consumed_s2[OUT_LEN_W-1:0];
		end else begin : g_len_ext
			assign result.decoded_length = {{(OUT_LEN_W-LENGTH_BITS){1'b0}}, decoded_s2};
			assign result.consumed_length = {{(OUT_LEN_W-LENGTH_BITS){1'b0}}, consumed_s2};
		end
	endgenerate

	a_byte_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && has_s2 |-> status_s2 == ST_RUNNING || status_s2 == ST_INCOMPLETE)
		else $error("decoded byte reported with a final status");

	a_done_holds_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !start_s1 && (ctl_q.phase == PH_DONE_OK || ctl_q.phase == PH_DONE_BAD)
		|=> $stable(decoded_q) && $stable(consumed_q))
		else $error("counters moved after the body ended");

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.phase == PH_DATA |-> left_q != '0)
		else $error("data phase with no bytes left");

	a_cr_in_size_line: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.pending_cr |-> ctl_q.phase == PH_SIZE)
		else $error("pending CR outside a size line");

endmodule

// File: rtl/core/hcd_step.sv
// Next-state and result logic for one raw byte of the chunked body.
// Purely combinational; depends on hcd_pkg.
module hcd_step
	import hcd_pkg::*;
#(
	parameter int SIZE_LIMIT_LOG2 = 40,
	parameter int LENGTH_BITS     = 48
) (
	input  logic [7:0]                 in_byte,
	input  logic                       start_req,
	input  logic                       in_last,
	input  hcd_ctl_t                   cur_ctl,
	input  logic [SIZE_LIMIT_LOG2:0]   cur_chunk,
	input  logic [SIZE_LIMIT_LOG2:0]   cur_left,
	input  logic [LENGTH_BITS-1:0]     cur_decoded,
	input  logic [LENGTH_BITS-1:0]     cur_consumed,
	output hcd_ctl_t                   nxt_ctl,
	output logic [SIZE_LIMIT_LOG2:0]   nxt_chunk,
	output logic [SIZE_LIMIT_LOG2:0]   nxt_left,
	output logic [LENGTH_BITS-1:0]     nxt_decoded,
	output logic [LENGTH_BITS-1:0]     nxt_consumed,
	output logic                       has_byte,
	output logic [7:0]                 out_byte,
	output status_t                    status
);

	localparam int CH_W = SIZE_LIMIT_LOG2 + 1;
	localparam int NV_W = CH_W + 4;
	localparam logic [NV_W-1:0] SIZE_LIMIT = NV_W'(1) << SIZE_LIMIT_LOG2;
	localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

	always_comb begin
		logic [4:0]      hex;
		logic [NV_W-1:0] nv;
		logic            go;
		logic            ok;
		hex = hex_digit(in_byte);
		nv = {cur_chunk, hex[3:0]};
		go = 1'b1;
		ok = 1'b0;
		nxt_ctl = cur_ctl;
		nxt_chunk = cur_chunk;
		nxt_left = cur_left;
		nxt_decoded = cur_decoded;
		nxt_consumed = cur_consumed;
		has_byte = 1'b0;
		out_byte = '0;
		if (start_req) begin
			nxt_ctl = CTL_RESET;
			nxt_chunk = '0;
			nxt_left = '0;
			nxt_decoded = '0;
			nxt_consumed = '0;
			nv = {CH_W'(0), hex[3:0]};
		end
		if (nxt_ctl.phase != PH_DONE_OK && nxt_ctl.phase != PH_DONE_BAD) begin
			if (nxt_consumed != CNT_MAX) begin
				nxt_consumed = nxt_consumed + LENGTH_BITS'(1);
			end
			case (nxt_ctl.phase)
				PH_SIZE: begin
					if (nxt_ctl.pending_cr) begin
						nxt_ctl.pending_cr = 1'b0;
						if (in_byte == CHAR_LF) begin
							go = 1'b0;
							if (nxt_ctl.line_bad) begin
								nxt_ctl.phase = PH_DONE_BAD;
							end else if (nxt_chunk == '0) begin
								nxt_ctl.phase = PH_LAST_CRLF;
								nxt_ctl.pair_second = 1'b0;
							end else begin
								nxt_left = nxt_chunk;
								nxt_ctl.phase = PH_DATA;
							end
						end else begin
							nxt_ctl.line_bad = 1'b1;
						end
					end
					if (go) begin
						if (in_byte == CHAR_CR) begin
							nxt_ctl.pending_cr = 1'b1;
						end else if (!hex[4]) begin
							nxt_ctl.line_bad = 1'b1;
						end else if (!nxt_ctl.line_bad) begin
							if (nv > SIZE_LIMIT) begin
								nxt_ctl.line_bad = 1'b1;
							end else begin
								nxt_chunk = nv[CH_W-1:0];
							end
						end
					end
				end
				PH_DATA: begin
					has_byte = 1'b1;
					out_byte = in_byte;
					if (nxt_decoded != CNT_MAX) begin
						nxt_decoded = nxt_decoded + LENGTH_BITS'(1);
					end
					if (nxt_left != '0) begin
						nxt_left = nxt_left - CH_W'(1);
					end
					if (nxt_left == '0) begin
						nxt_ctl.phase = PH_DATA_CRLF;
						nxt_ctl.pair_second = 1'b0;
					end
				end
				default: begin
					if (!nxt_ctl.pair_second) begin
						nxt_ctl.first_ok = (in_byte == CHAR_CR);
						nxt_ctl.pair_second = 1'b1;
					end else begin
						nxt_ctl.pair_second = 1'b0;
						ok = nxt_ctl.first_ok && (in_byte == CHAR_LF);
						if (nxt_ctl.phase == PH_DATA_CRLF) begin
							if (ok) begin
								nxt_ctl.phase = PH_SIZE;
								nxt_chunk = '0;
								nxt_ctl.line_bad = 1'b0;
								nxt_ctl.pending_cr = 1'b0;
							end else begin
								nxt_ctl.phase = PH_DONE_BAD;
							end
						end else begin
							nxt_ctl.phase = ok ? PH_DONE_OK : PH_DONE_BAD;
						end
					end
				end
			endcase
		end
		if (nxt_ctl.phase == PH_DONE_OK) begin
			status = ST_COMPLETE;
		end else if (nxt_ctl.phase == PH_DONE_BAD) begin
			status = ST_MALFORMED;
		end else begin
			status = in_last ? ST_INCOMPLETE : ST_RUNNING;
		end
	end

endmodule
